### rtl/core/rlm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlm_pkg: shared types and constants for the run-length layer merge
// Field masks, layer select codes and the status bundle carried by results.
// ----------------------------------------------------------------------------
package rlm_pkg;

	localparam int PIXEL_COUNT_BITS = 24;

	localparam logic [PIXEL_COUNT_BITS-1:0] IMAGE_PIXELS_RESET = PIXEL_COUNT_BITS'(6144);

	localparam logic [3:0] TRANSPARENT_IDX = 4'hf;
	localparam logic [4:0] UPPER_BASE      = 5'd16;
	localparam logic [2:0] RUN5_MAX_M1     = 3'd7;

	typedef enum logic {
		CMD_LOWER = 1'b0,
		CMD_UPPER = 1'b1
	} layer_cmd_t;

	typedef struct packed {
		logic need_lower;
		logic need_upper;
		logic image_done;
		logic misfed;
	} status_t;

endpackage
`default_nettype wire

### rtl/core/rle_layer_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_layer_merge: merge a 16-colour lower and a 15-colour upper run-length layer into one stream
// Input register, combinational merge logic, result register plus one
// pending slot for the second chunk of a run longer than eight pixels.
// ----------------------------------------------------------------------------
// path: an accepted request is held in the input register, then merged into the result register
// throughput: one result per cycle while out_ready holds; one request per cycle when it yields one
//   result; a run over eight pixels splits into two entries and holds the next request back
// the result register and pending slot hold the two entries of a split run
// reset: layer runs, colours and pixel count clear, image_pixels goes to 6144
module rle_layer_merge (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 image_pixels_we,
	input  wire logic [rlm_pkg::PIXEL_COUNT_BITS-1:0] image_pixels,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 command,
	input  wire logic [7:0]                           entry,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [7:0]                                merged_entry,
	output logic                                      entry_valid,
	output logic                                      last,
	output logic                                      need_lower,
	output logic                                      need_upper,
	output logic                                      image_done,
	output logic                                      misfed
);

	localparam int PB = rlm_pkg::PIXEL_COUNT_BITS;

	// input register
	logic       valid_s1;
	logic       command_s1;
	logic [7:0] entry_s1;

	// layer state
	logic [4:0]  lower_left_q, upper_left_q;
	logic [3:0]  lower_colour_q, upper_colour_q;
	logic [PB:0] pixels_done_q;
	logic [PB-1:0] image_pixels_q;

	// result register and pending second chunk
	logic             out_valid_q;
	logic [7:0]       out_entry_q;
	logic             out_entry_valid_q;
	logic             out_last_q;
	rlm_pkg::status_t out_status_q;
	logic             pend_valid_q;
	logic [7:0]       pend_entry_q;

	logic proc_ok, process;

	// merge logic
	logic             is_upper, mis_c, overlap_c, two_c, done_c;
	logic [4:0]       new_len, low_l, up_l, run, low_next, up_next;
	logic [3:0]       low_c, up_c, run_m1;
	logic [4:0]       idx;
	logic [PB:0]      sum;
	logic [7:0]       first_entry, second_entry;
	rlm_pkg::status_t status_c;

	assign proc_ok  = !pend_valid_q && (!out_valid_q || out_ready);
	assign process  = valid_s1 && proc_ok;
	assign in_ready = !valid_s1 || proc_ok;

	always_comb begin
		is_upper = (command_s1 == rlm_pkg::CMD_UPPER);
		mis_c    = is_upper ? (upper_left_q != 5'd0) : (lower_left_q != 5'd0);
		new_len  = {1'b0, entry_s1[7:4]} + 5'd1;
		low_l    = lower_left_q;
		low_c    = lower_colour_q;
		up_l     = upper_left_q;
		up_c     = upper_colour_q;
		if (!mis_c) begin
			if (is_upper) begin
				up_l = new_len;
				up_c = entry_s1[3:0];
			end else begin
				low_l = new_len;
				low_c = entry_s1[3:0];
			end
		end
		overlap_c = !mis_c && (low_l != 5'd0) && (up_l != 5'd0);
		run       = overlap_c ? ((low_l < up_l) ? low_l : up_l) : 5'd0;
		low_next  = low_l - run;
		up_next   = up_l - run;
		idx       = (up_c == rlm_pkg::TRANSPARENT_IDX) ? {1'b0, low_c}
		                                               : (rlm_pkg::UPPER_BASE | {1'b0, up_c});
		// run is 1..16 on overlap, so run-1 fits four bits
		run_m1    = 4'(run - 5'd1);
		two_c     = overlap_c && run_m1[3];
		sum       = pixels_done_q + (PB+1)'(run);
		done_c    = overlap_c && (sum >= {1'b0, image_pixels_q});
		// a second chunk carries the low three bits of run-1, which is run-9
		first_entry  = two_c ? {rlm_pkg::RUN5_MAX_M1, idx} : {run_m1[2:0], idx};
		second_entry = {run_m1[2:0], idx};
		status_c.need_lower = done_c || (low_next == 5'd0);
		status_c.need_upper = done_c || (up_next == 5'd0);
		status_c.image_done = done_c;
		status_c.misfed     = mis_c;
	end

	// control and layer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			pend_valid_q   <= 1'b0;
			lower_left_q   <= 5'd0;
			upper_left_q   <= 5'd0;
			lower_colour_q <= 4'd0;
			upper_colour_q <= 4'd0;
			pixels_done_q  <= '0;
			image_pixels_q <= rlm_pkg::IMAGE_PIXELS_RESET;
		end else begin
			if (image_pixels_we) begin
				image_pixels_q <= image_pixels;
			end
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (process) begin
				valid_s1 <= 1'b0;
			end
			if (process) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= two_c;
				if (done_c) begin
					lower_left_q   <= 5'd0;
					upper_left_q   <= 5'd0;
					lower_colour_q <= 4'd0;
					upper_colour_q <= 4'd0;
					pixels_done_q  <= '0;
				end else begin
					lower_left_q   <= low_next;
					upper_left_q   <= up_next;
					lower_colour_q <= low_c;
					upper_colour_q <= up_c;
					if (overlap_c) begin
						pixels_done_q <= sum;
					end
				end
			end else if (out_valid_q && out_ready) begin
				// pending chunk moves up, otherwise the result register drains
				out_valid_q  <= pend_valid_q;
				pend_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= command;
			entry_s1   <= entry;
		end
		if (process) begin
			out_entry_q       <= overlap_c ? first_entry : 8'd0;
			out_entry_valid_q <= overlap_c;
			out_last_q        <= !two_c;
			out_status_q      <= status_c;
			pend_entry_q      <= second_entry;
		end else if (out_valid_q && out_ready && pend_valid_q) begin
			out_entry_q <= pend_entry_q;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign merged_entry = out_entry_q;
	assign entry_valid  = out_entry_valid_q;
	assign last         = out_last_q;
	assign need_lower   = out_status_q.need_lower;
	assign need_upper   = out_status_q.need_upper;
	assign image_done   = out_status_q.image_done;
	assign misfed       = out_status_q.misfed;

endmodule
`default_nettype wire

### rtl/core/rlm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlm_checker: port-level checks for the run-length layer merge
// Watches the result channel for chunk ordering and status consistency.
// ----------------------------------------------------------------------------
module rlm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] merged_entry,
	input wire logic       entry_valid,
	input wire logic       last,
	input wire logic       need_lower,
	input wire logic       need_upper,
	input wire logic       image_done,
	input wire logic       misfed
);

	// a first chunk is always followed at once by the second
	a_second_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && entry_valid && last)
		else $error("second chunk of a split run missing");

	// status-only results are single and carry an empty entry
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> last && (merged_entry == 8'd0))
		else $error("status-only result malformed");

	// a dropped entry produces no pixels
	a_misfed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && misfed |-> !entry_valid && !image_done)
		else $error("misfed request emitted pixels");

	// finishing an image leaves both layers empty
	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> need_lower && need_upper && entry_valid)
		else $error("image done with a layer still holding a run");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(merged_entry) && $stable(last))
		else $error("stalled result changed");

endmodule

bind rle_layer_merge rlm_checker u_rlm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.merged_entry (merged_entry),
	.entry_valid  (entry_valid),
	.last         (last),
	.need_lower   (need_lower),
	.need_upper   (need_upper),
	.image_done   (image_done),
	.misfed       (misfed)
);
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: layer merge check for rle_layer_merge
// Feeds lower and upper layer entries, mostly as well-formed refill sequences,
// predicts the merged entries and status of every request, and compares each
// result in order. Image size changes between phases, idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import rlm_pkg::*;

	typedef struct packed {
		logic [7:0] merged_entry;
		logic       entry_valid;
		logic       last;
		logic       need_lower;
		logic       need_upper;
		logic       image_done;
		logic       misfed;
	} merge_result_t;

	class merge_scoreboard;
		merge_result_t                  expected_q[$];
		logic [PIXEL_COUNT_BITS-1:0]    image_size;
		logic [4:0]                     lower_left;
		logic [4:0]                     upper_left;
		logic [3:0]                     lower_colour;
		logic [3:0]                     upper_colour;
		logic [PIXEL_COUNT_BITS:0]      pixels_done;
		int                             errors;
		int                             requests;
		int                             entries;
		int                             images;
		int                             misfeds;

		function new();
			image_size   = IMAGE_PIXELS_RESET;
			lower_left   = '0;
			upper_left   = '0;
			lower_colour = '0;
			upper_colour = '0;
			pixels_done  = '0;
			errors       = 0;
			requests     = 0;
			entries      = 0;
			images       = 0;
			misfeds      = 0;
		endfunction

		function void set_size(logic [PIXEL_COUNT_BITS-1:0] v);
			image_size = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// work out the merged entries that one accepted request yields
		function void note_request(layer_cmd_t cmd, logic [7:0] ent);
			merge_result_t r;
			logic [4:0]    run;
			logic [4:0]    idx;
			logic [4:0]    len_m1;
			logic          done;
			requests++;
			r = '0;
			r.last = 1'b1;
			if ((cmd == CMD_LOWER && lower_left != 0) || (cmd == CMD_UPPER && upper_left != 0)) begin
				r.misfed     = 1'b1;
				r.need_lower = (lower_left == 0);
				r.need_upper = (upper_left == 0);
				expected_q.push_back(r);
				return;
			end
			if (cmd == CMD_LOWER) begin
				lower_left   = {1'b0, ent[7:4]} + 5'd1;
				lower_colour = ent[3:0];
			end else begin
				upper_left   = {1'b0, ent[7:4]} + 5'd1;
				upper_colour = ent[3:0];
			end
			if (lower_left == 0 || upper_left == 0) begin
				r.need_lower = (lower_left == 0);
				r.need_upper = (upper_left == 0);
				expected_q.push_back(r);
				return;
			end
			run = (lower_left < upper_left) ? lower_left : upper_left;
			lower_left -= run;
			upper_left -= run;
			// transparent upper pixels show the lower colour
			idx = (upper_colour == TRANSPARENT_IDX) ? {1'b0, lower_colour}
				: {1'b0, upper_colour} + UPPER_BASE;
			pixels_done = pixels_done + {{(PIXEL_COUNT_BITS - 4){1'b0}}, run};
			done = (pixels_done >= {1'b0, image_size});
			if (done) begin
				lower_left   = '0;
				upper_left   = '0;
				lower_colour = '0;
				upper_colour = '0;
				pixels_done  = '0;
			end
			r.entry_valid = 1'b1;
			r.need_lower  = (lower_left == 0);
			r.need_upper  = (upper_left == 0);
			r.image_done  = done;
			// runs over eight pixels split into a full chunk and the rest
			len_m1 = (run > 5'd8) ? 5'd7 : run - 5'd1;
			r.merged_entry = {len_m1[2:0], idx};
			r.last = (run <= 5'd8);
			expected_q.push_back(r);
			if (run > 5'd8) begin
				len_m1 = run - 5'd9;
				r.merged_entry = {len_m1[2:0], idx};
				r.last = 1'b1;
				expected_q.push_back(r);
			end
		endfunction

		function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
			if (exp_v !== got_v) begin
				$error("%s: expected 0x%02h, got 0x%02h", name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(merge_result_t got);
			merge_result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("result 0x%02h arrived with no request outstanding", got.merged_entry);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			compare_field("merged_entry", exp_r.merged_entry, got.merged_entry);
			compare_field("entry_valid", {7'd0, exp_r.entry_valid}, {7'd0, got.entry_valid});
			compare_field("last", {7'd0, exp_r.last}, {7'd0, got.last});
			compare_field("need_lower", {7'd0, exp_r.need_lower}, {7'd0, got.need_lower});
			compare_field("need_upper", {7'd0, exp_r.need_upper}, {7'd0, got.need_upper});
			compare_field("image_done", {7'd0, exp_r.image_done}, {7'd0, got.image_done});
			compare_field("misfed", {7'd0, exp_r.misfed}, {7'd0, got.misfed});
			if (got.entry_valid === 1'b1)
				entries++;
			if (got.last === 1'b1 && got.image_done === 1'b1)
				images++;
			if (got.misfed === 1'b1)
				misfeds++;
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        image_pixels_we;
	logic [PIXEL_COUNT_BITS-1:0] image_pixels;
	logic                        in_valid;
	logic                        in_ready;
	logic                        command;
	logic [7:0]                  entry;
	logic                        out_valid;
	logic                        out_ready;
	logic [7:0]                  merged_entry;
	logic                        entry_valid;
	logic                        last;
	logic                        need_lower;
	logic                        need_upper;
	logic                        image_done;
	logic                        misfed;

	merge_scoreboard sb = new();

	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_start;
	int hold_cycles;

	rle_layer_merge dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.image_pixels_we (image_pixels_we),
		.image_pixels    (image_pixels),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.entry           (entry),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.merged_entry    (merged_entry),
		.entry_valid     (entry_valid),
		.last            (last),
		.need_lower      (need_lower),
		.need_upper      (need_upper),
		.image_done      (image_done),
		.misfed          (misfed)
	);

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		out_ready   = 1'b0;
		hold_cycles = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else if (hold_start) begin
				hold_start  = 1'b0;
				hold_cycles = 150;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({merged_entry, entry_valid, last, need_lower, need_upper,
				image_done, misfed});
	end

	task automatic send_request(layer_cmd_t cmd, logic [7:0] ent);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		entry    <= ent;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(cmd, ent);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic write_image_size(logic [PIXEL_COUNT_BITS-1:0] v);
		wait_drained();
		// let the pipeline settle before the size is written
		repeat (4) @(posedge clk);
		image_pixels_we <= 1'b1;
		image_pixels    <= v;
		@(posedge clk);
		image_pixels_we <= 1'b0;
		sb.set_size(v);
	endtask

	// mostly refill whichever layer ran dry, sometimes a stray entry
	task automatic feed_random(int count, bit pause_midway);
		layer_cmd_t cmd;
		logic [7:0] ent;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				wait_drained();
			if ($urandom_range(99) < 88) begin
				if (sb.lower_left == 0 && sb.upper_left == 0)
					cmd = layer_cmd_t'($urandom_range(1));
				else if (sb.lower_left == 0)
					cmd = CMD_LOWER;
				else
					cmd = CMD_UPPER;
			end else begin
				cmd = layer_cmd_t'($urandom_range(1));
			end
			ent = 8'($urandom_range(255));
			if (cmd == CMD_UPPER && $urandom_range(3) == 0)
				ent[3:0] = TRANSPARENT_IDX;
			send_request(cmd, ent);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		image_pixels_we = 1'b0;
		image_pixels    = '0;
		in_valid        = 1'b0;
		command         = 1'b0;
		entry           = '0;
		hold_start      = 1'b0;
		tx_idle_pct     = 9;
		rx_idle_pct     = 77;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset image size, splits, transparency, misfeeds
		send_request(CMD_LOWER, 8'h00);
		send_request(CMD_LOWER, 8'h35);
		send_request(CMD_UPPER, 8'h0f);
		send_request(CMD_UPPER, 8'hf0);
		send_request(CMD_UPPER, 8'h11);
		send_request(CMD_LOWER, 8'hff);
		send_request(CMD_LOWER, 8'h7e);
		send_request(CMD_UPPER, 8'h9e);
		send_request(CMD_LOWER, 8'h2f);
		send_request(CMD_UPPER, 8'h8f);
		send_request(CMD_LOWER, 8'hf5);
		send_request(CMD_UPPER, 8'h80);
		send_request(CMD_LOWER, 8'h01);
		send_request(CMD_UPPER, 8'h0a);
		send_request(CMD_LOWER, 8'h93);
		send_request(CMD_UPPER, 8'hcf);
		// one-pixel image ends on every overlap, mid-image size change
		write_image_size(24'd1);
		send_request(CMD_UPPER, 8'hf3);
		send_request(CMD_LOWER, 8'h3c);
		send_request(CMD_LOWER, 8'hf6);
		send_request(CMD_UPPER, 8'hff);
		// zero size also ends the image on every overlap
		write_image_size(24'd0);
		send_request(CMD_LOWER, 8'h88);
		send_request(CMD_UPPER, 8'h40);
		write_image_size(24'hffffff);
		send_request(CMD_LOWER, 8'hf0);
		send_request(CMD_UPPER, 8'hf7);

		write_image_size(24'($urandom_range(1, 40)));
		feed_random(270, 1'b0);
		write_image_size(IMAGE_PIXELS_RESET);
		feed_random(270, 1'b0);

		tx_idle_pct = 77;
		rx_idle_pct = 9;
		write_image_size(24'($urandom_range(41, 700)));
		hold_start = 1'b1;
		feed_random(270, 1'b0);
		write_image_size(24'd1);
		feed_random(270, 1'b0);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_image_size(24'($urandom_range(1, 200)));
		hold_start = 1'b1;
		feed_random(270, 1'b1);
		write_image_size(24'hffffff);
		feed_random(270, 1'b0);

		wait_drained();
		repeat (10) @(posedge clk);
		$display("covered %0d requests, %0d merged entries, %0d images, %0d misfed entries",
			sb.requests, sb.entries, sb.images, sb.misfeds);
		$display("image sizes from zero to full scale, idling and long stalls on both sides");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/core/rlm_pkg.sv
rtl/core/rle_layer_merge.sv
rtl/core/rlm_checker.sv
dv/testbench.sv
